// ===== rtl/col_pkg.sv =====
// Shared types and constants for the cursor ordered list.
`timescale 1ns / 1ps
`default_nettype none
package col_pkg;

    localparam int CAPACITY_ITEMS_DEF = 32;
    localparam int VALUE_WIDTH_DEF    = 32;

    localparam int ACTION_W     = 3;
    localparam int FIELD_W      = 32;
    localparam int ITEM_COUNT_W = 6;

    localparam logic [ACTION_W-1:0] ACT_START   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ATTACH  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FIELD_W-1:0]  entry_value;
    } req_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]      current_value;
        logic                    has_current;
        logic [ITEM_COUNT_W-1:0] item_count;
        logic                    full_rejected;
    } rsp_item_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic open_gap;   // cells above pos take from below, cell at pos loads
        logic close_gap;  // cells at or above pos take from above
    } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/col_cell.sv =====
// One storage cell of the list row; shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module col_cell #(
    parameter int IDX         = 0,
    parameter int POS_W       = 6,
    parameter int VALUE_WIDTH = col_pkg::VALUE_WIDTH_DEF
) (
    input  wire                    clk,
    input  wire col_pkg::cell_cmd_t cmd,
    input  wire [POS_W-1:0]        pos,
    input  wire [VALUE_WIDTH-1:0]  wval,
    input  wire [VALUE_WIDTH-1:0]  below_val,
    input  wire [VALUE_WIDTH-1:0]  above_val,
    output logic [VALUE_WIDTH-1:0] val
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.open_gap)
        begin
            if (MY_POS == pos)
                val_next = wval;
            else if (MY_POS > pos)
                val_next = below_val;
        end
        else if (cmd.close_gap)
        begin
            if (MY_POS >= pos)
                val_next = above_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule
`default_nettype wire

// ===== rtl/cursor_ordered_list.sv =====
// Top level: cursor ordered list built from a row of shifting cells.
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to CAPACITY_ITEMS values with a cursor. Each item is
// handled in two steps: on accept the whole row of cells shifts at once to
// open or close a gap and the cursor and count update; then, once the result
// register is free, the entry under the cursor is selected from the row into
// it. req_stall is high while an accepted item waits for that second step,
// so no new item enters until then. A result that waits on rsp_stall does not
// hold up the next item's row update, but after that update req_stall stays
// high until the waiting result leaves. Entries need no clearing after reset:
// only written cells are ever read.
module cursor_ordered_list #(
    parameter int CAPACITY_ITEMS = col_pkg::CAPACITY_ITEMS_DEF,
    parameter int VALUE_WIDTH    = col_pkg::VALUE_WIDTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  wire col_pkg::req_item_t req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output col_pkg::rsp_item_t  rsp
);

    localparam int CW = $clog2(CAPACITY_ITEMS + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY_ITEMS);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic          rej_reg, rej_next;
    logic          pend_reg;
    logic          rsp_valid_reg;
    col_pkg::rsp_item_t rsp_reg;

    col_pkg::cell_cmd_t     cmd;
    logic [CW-1:0]          pos;
    logic [VALUE_WIDTH-1:0] wval;
    logic [VALUE_WIDTH-1:0] cell_val [CAPACITY_ITEMS];
    logic [VALUE_WIDTH-1:0] sel_val;

    logic accept;
    logic on_item;
    logic full;

    assign accept    = req_valid & ~req_stall;
    assign req_stall = pend_reg;
    assign on_item   = cur_reg < cnt_reg;
    assign full      = cnt_reg == CAP;
    assign wval      = VALUE_WIDTH'(req.entry_value);

    always_comb
    begin
        cnt_next = cnt_reg;
        cur_next = cur_reg;
        rej_next = 1'b0;
        cmd      = '0;
        pos      = cur_reg;
        unique case (req.action)
            col_pkg::ACT_START:
                cur_next = '0;
            col_pkg::ACT_ADVANCE:
                if (on_item)
                    cur_next = cur_reg + 1'b1;
            col_pkg::ACT_INSERT:
                if (full)
                    rej_next = 1'b1;
                else
                begin
                    pos          = on_item ? cur_reg : '0;
                    cmd.open_gap = 1'b1;
                    cur_next     = pos;
                    cnt_next     = cnt_reg + 1'b1;
                end
            col_pkg::ACT_ATTACH:
                if (full)
                    rej_next = 1'b1;
                else
                begin
                    pos          = on_item ? cur_reg + 1'b1 : cnt_reg;
                    cmd.open_gap = 1'b1;
                    cur_next     = pos;
                    cnt_next     = cnt_reg + 1'b1;
                end
            col_pkg::ACT_REMOVE:
                if (on_item)
                begin
                    cmd.close_gap = 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                end
            default:
                ;
        endcase
        // Cells move only on an accepted item
        if (!accept)
            cmd = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY_ITEMS; gi++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] below_v;
            logic [VALUE_WIDTH-1:0] above_v;
            if (gi == 0)
            begin : g_first
                assign below_v = '0;
            end
            else
            begin : g_mid_lo
                assign below_v = cell_val[gi-1];
            end
            if (gi == CAPACITY_ITEMS - 1)
            begin : g_last
                assign above_v = cell_val[gi];
            end
            else
            begin : g_mid_hi
                assign above_v = cell_val[gi+1];
            end
            col_cell #(
                .IDX         (gi),
                .POS_W       (CW),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .pos       (pos),
                .wval      (wval),
                .below_val (below_v),
                .above_val (above_v),
                .val       (cell_val[gi])
            );
        end
    endgenerate

    // Pick the entry under the cursor: gate each cell and OR the row
    always_comb
    begin
        sel_val = '0;
        for (int i = 0; i < CAPACITY_ITEMS; i++)
        begin
            if (cur_reg == CW'(i))
                sel_val = sel_val | cell_val[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            cur_reg       <= '0;
            rej_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg  <= cnt_next;
                cur_reg  <= cur_next;
                rej_reg  <= rej_next;
                pend_reg <= 1'b1;
            end
            if (pend_reg && (!rsp_valid_reg || !rsp_stall))
            begin
                pend_reg      <= 1'b0;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_reg.current_value <= on_item ? col_pkg::FIELD_W'(sel_val) : '0;
            rsp_reg.has_current   <= on_item;
            rsp_reg.item_count    <= col_pkg::ITEM_COUNT_W'(cnt_reg);
            rsp_reg.full_rejected <= rej_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP)
        else $error("item count beyond capacity");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= cnt_reg)
        else $error("cursor beyond item count");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !(rsp_valid_reg && rsp_stall) |=> rsp_valid_reg && !pend_reg)
        else $error("pending item did not reach result register");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        accept && full &&
        (req.action == col_pkg::ACT_INSERT || req.action == col_pkg::ACT_ATTACH)
        |=> rej_reg && $stable(cnt_reg) && $stable(cur_reg))
        else $error("full list changed on insert or attach");

endmodule
`default_nettype wire
